// ===== src/dsps_pkg.sv =====
`timescale 1ns / 1ps

package dsps_pkg;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_RATIO       = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_FREQUENCY      = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY_PER_SPEED = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_SETTING       = 8'd3;

	localparam logic [15:0] DAMPING_RATIO_RESET       = 16'd13107;
	localparam logic [15:0] BASE_FREQUENCY_RESET      = 16'd2432;
	localparam logic [15:0] FREQUENCY_PER_SPEED_RESET = 16'd51;
	localparam logic [7:0]  SPEED_SETTING_RESET       = 8'd50;

	localparam logic [15:0] DT_DEFAULT_US = 16'd16667;
	localparam logic [15:0] DT_MAX_US     = 16'd33333;
	localparam logic [47:0] DT_BIAS       = 48'd500000;
	localparam logic [19:0] US_PER_S      = 20'd1000000;
	localparam logic [28:0] DT_RECIP      = 29'd281474976;

	localparam logic [61:0] TERM_CAP = 62'h2000_0000_0000_0000;
	localparam logic signed [32:0] SNAP_HALF = 33'sd32768;

	typedef struct packed {
		logic signed [31:0] target_position;
		logic [15:0]        frame_time_us;
	} item_t;

	typedef struct packed {
		logic signed [31:0] position_out;
		logic signed [31:0] velocity_out;
		logic               settled;
	} result_t;

	typedef logic [5:0] step_t;

	localparam step_t START_STEP = 6'd0;
	localparam step_t LAST_STEP  = 6'd36;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_LOAD,
		OP_MUL,
		OP_STORE,
		OP_FIXDT,
		OP_VEL,
		OP_POS,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		A_PER_SPEED,
		A_OMEGA,
		A_DT_NUM,
		A_DT,
		A_VEL,
		A_ERR,
		A_ACC,
		A_V1
	} a_src_t;

	typedef enum logic [2:0] {
		B_SPEED,
		B_ZETA2,
		B_OMEGA,
		B_RECIP,
		B_US_PER_S,
		B_K1,
		B_W2,
		B_DT
	} b_src_t;

	typedef enum logic [1:0] {
		INIT_ZERO,
		INIT_HALF,
		INIT_BASE
	} init_t;

	typedef enum logic [2:0] {
		SH_0,
		SH_16,
		SH_22,
		SH_32,
		SH_48
	} sh_t;

	typedef enum logic [2:0] {
		D_OMEGA,
		D_K1,
		D_W2,
		D_DT,
		D_T1,
		D_T2,
		D_DV,
		D_DX
	} dest_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_ITEM,
		SEQ_WAIT_SLOT
	} seq_t;

	typedef struct packed {
		op_t    op;
		a_src_t asrc;
		b_src_t bsrc;
		init_t  init;
		logic   a_hi;
		logic   b_hi;
		sh_t    sh;
		dest_t  dest;
		seq_t   seq;
		step_t  target;
	} ucode_t;

	typedef struct packed {
		logic  load;
		logic  mul;
		logic  a_hi;
		logic  b_hi;
		init_t init;
		sh_t   sh;
	} mac_ctl_t;

	function automatic ucode_t uw_op(op_t op, seq_t seq);
		ucode_t w;
		w = '0;
		w.op = op;
		w.seq = seq;
		w.target = START_STEP;
		return w;
	endfunction

	function automatic ucode_t uw_load(a_src_t a, b_src_t b, init_t init, sh_t sh);
		ucode_t w;
		w = uw_op(OP_LOAD, SEQ_NEXT);
		w.asrc = a;
		w.bsrc = b;
		w.init = init;
		w.sh = sh;
		return w;
	endfunction

	function automatic ucode_t uw_mul(logic a_hi, logic b_hi);
		ucode_t w;
		w = uw_op(OP_MUL, SEQ_NEXT);
		w.a_hi = a_hi;
		w.b_hi = b_hi;
		return w;
	endfunction

	function automatic ucode_t uw_store(sh_t sh, dest_t dest);
		ucode_t w;
		w = uw_op(OP_STORE, SEQ_NEXT);
		w.sh = sh;
		w.dest = dest;
		return w;
	endfunction

	// The step program. Each product is formed from 32-bit chunks of the operands.
	function automatic ucode_t ucode_rom(step_t pc);
		ucode_t w;
		unique case (pc)
			6'd0:  w = uw_op(OP_ACCEPT, SEQ_WAIT_ITEM);
			6'd1:  w = uw_load(A_PER_SPEED, B_SPEED, INIT_BASE, SH_0);
			6'd2:  w = uw_mul(1'b0, 1'b0);
			6'd3:  w = uw_store(SH_0, D_OMEGA);
			6'd4:  w = uw_load(A_OMEGA, B_ZETA2, INIT_ZERO, SH_0);
			6'd5:  w = uw_mul(1'b0, 1'b0);
			6'd6:  w = uw_store(SH_0, D_K1);
			6'd7:  w = uw_load(A_OMEGA, B_OMEGA, INIT_ZERO, SH_0);
			6'd8:  w = uw_mul(1'b0, 1'b0);
			6'd9:  w = uw_store(SH_0, D_W2);
			6'd10: w = uw_load(A_DT_NUM, B_RECIP, INIT_ZERO, SH_48);
			6'd11: w = uw_mul(1'b0, 1'b0);
			6'd12: w = uw_mul(1'b1, 1'b0);
			6'd13: w = uw_store(SH_48, D_DT);
			6'd14: w = uw_load(A_DT, B_US_PER_S, INIT_ZERO, SH_0);
			6'd15: w = uw_mul(1'b0, 1'b0);
			6'd16: w = uw_op(OP_FIXDT, SEQ_NEXT);
			6'd17: w = uw_load(A_VEL, B_K1, INIT_HALF, SH_22);
			6'd18: w = uw_mul(1'b0, 1'b0);
			6'd19: w = uw_mul(1'b0, 1'b1);
			6'd20: w = uw_store(SH_22, D_T1);
			6'd21: w = uw_load(A_ERR, B_W2, INIT_HALF, SH_16);
			6'd22: w = uw_mul(1'b0, 1'b0);
			6'd23: w = uw_mul(1'b0, 1'b1);
			6'd24: w = uw_mul(1'b1, 1'b0);
			6'd25: w = uw_mul(1'b1, 1'b1);
			6'd26: w = uw_store(SH_16, D_T2);
			6'd27: w = uw_load(A_ACC, B_DT, INIT_HALF, SH_32);
			6'd28: w = uw_mul(1'b0, 1'b0);
			6'd29: w = uw_mul(1'b1, 1'b0);
			6'd30: w = uw_store(SH_32, D_DV);
			6'd31: w = uw_op(OP_VEL, SEQ_NEXT);
			6'd32: w = uw_load(A_V1, B_DT, INIT_HALF, SH_32);
			6'd33: w = uw_mul(1'b0, 1'b0);
			6'd34: w = uw_store(SH_32, D_DX);
			6'd35: w = uw_op(OP_POS, SEQ_NEXT);
			6'd36: w = uw_op(OP_FINISH, SEQ_WAIT_SLOT);
			default: w = uw_op(OP_NOP, SEQ_WAIT_SLOT);
		endcase
		return w;
	endfunction

endpackage

// ===== src/damped_spring_position_step.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Beat
// item      item_valid / item_stall   item_t: target_position, frame_time_us
// result    result_valid / result_stall result_t: position_out, velocity_out, settled
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A new item is accepted only once the 37-step control program has finished the last one;
// the program runs every product through one 32x32 multiply-accumulate unit.
// The result beat is registered at the final step of the program, once the result slot is free.
// Reset loads the register presets and clears position and velocity; there is no clearing pass.
// item_stall is high while the program runs; a stalled result holds only the final step.

module damped_spring_position_step (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  dsps_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output dsps_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dsps_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dsps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dsps_pkg::*;

	step_t    pc_q;
	ucode_t   uw;
	logic     accept;
	logic     slot_free;
	logic     go;
	mac_ctl_t mac_ctl;

	logic [15:0] zeta_q;
	logic [15:0] base_q;
	logic [15:0] per_speed_q;
	logic [7:0]  speed_q;

	logic signed [31:0] x_q;
	logic signed [31:0] v_q;
	logic               result_valid_q;
	result_t            result_q;

	logic signed [31:0] tgt_q;
	logic [15:0]        us_q;
	logic signed [32:0] err0_q;
	logic [23:0]        omega_q;
	logic [40:0]        k1_q;
	logic [47:0]        w2_q;
	logic [27:0]        dt_q;
	logic signed [50:0] t1_q;
	logic signed [62:0] t2_q;
	logic signed [59:0] dv_q;
	logic signed [28:0] dx_q;
	logic signed [31:0] v1_q;
	logic signed [31:0] x1_q;

	logic [15:0]        us_eff;
	logic signed [32:0] err0_in;
	logic [47:0]        dt_num;
	logic [47:0]        dt_rem;
	logic               dt_carry;
	logic signed [63:0] neg_sum;
	logic signed [60:0] vel_sum;
	logic signed [32:0] pos_sum;
	logic signed [32:0] err1;
	logic               snap;
	logic signed [63:0] a_src;
	logic [63:0]        b_src;
	logic signed [63:0] mac_res;
	logic [47:0]        mac_acc_low;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	always_comb begin
		uw = ucode_rom(pc_q);
		item_stall = (uw.seq != SEQ_WAIT_ITEM);
		accept = item_valid && !item_stall;
		slot_free = !result_valid_q || !result_stall;
		unique case (uw.seq)
			SEQ_NEXT:      go = 1'b1;
			SEQ_WAIT_ITEM: go = accept;
			SEQ_WAIT_SLOT: go = slot_free;
			default:       go = 1'b0;
		endcase
		mac_ctl.load = go && (uw.op == OP_LOAD);
		mac_ctl.mul = go && (uw.op == OP_MUL);
		mac_ctl.a_hi = uw.a_hi;
		mac_ctl.b_hi = uw.b_hi;
		mac_ctl.init = uw.init;
		mac_ctl.sh = uw.sh;

		if (item.frame_time_us == 16'd0) begin
			us_eff = DT_DEFAULT_US;
		end else if (item.frame_time_us > DT_MAX_US) begin
			us_eff = DT_MAX_US;
		end else begin
			us_eff = item.frame_time_us;
		end
		err0_in = $signed({x_q[31], x_q}) - $signed({item.target_position[31],
			item.target_position});

		dt_num = {us_q, 32'd0} + DT_BIAS;
		dt_rem = dt_num - mac_acc_low;
		dt_carry = (dt_rem >= 48'(US_PER_S));

		neg_sum = -$signed({{13{t1_q[50]}}, t1_q}) - $signed({t2_q[62], t2_q});
		vel_sum = $signed({{29{v_q[31]}}, v_q}) + $signed({dv_q[59], dv_q});
		pos_sum = $signed({x_q[31], x_q}) + $signed({{4{dx_q[28]}}, dx_q});
		err1 = $signed({x1_q[31], x1_q}) - $signed({tgt_q[31], tgt_q});
		snap = (err0_q <= 0 && err1 >= 0) || (err0_q >= 0 && err1 <= 0) ||
			(err1 > -SNAP_HALF && err1 < SNAP_HALF);

		unique case (uw.asrc)
			A_PER_SPEED: a_src = $signed({48'd0, per_speed_q});
			A_OMEGA:     a_src = $signed({40'd0, omega_q});
			A_DT_NUM:    a_src = $signed({16'd0, dt_num});
			A_DT:        a_src = $signed({36'd0, dt_q});
			A_VEL:       a_src = $signed({{32{v_q[31]}}, v_q});
			A_ERR:       a_src = $signed({{31{err0_q[32]}}, err0_q});
			A_ACC:       a_src = neg_sum;
			A_V1:        a_src = $signed({{32{v1_q[31]}}, v1_q});
			default:     a_src = '0;
		endcase
		unique case (uw.bsrc)
			B_SPEED:    b_src = {56'd0, speed_q};
			B_ZETA2:    b_src = {47'd0, zeta_q, 1'b0};
			B_OMEGA:    b_src = {40'd0, omega_q};
			B_RECIP:    b_src = {35'd0, DT_RECIP};
			B_US_PER_S: b_src = {44'd0, US_PER_S};
			B_K1:       b_src = {23'd0, k1_q};
			B_W2:       b_src = {16'd0, w2_q};
			B_DT:       b_src = {36'd0, dt_q};
			default:    b_src = '0;
		endcase
	end

	dsps_mac u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.a_src   (a_src),
		.b_src   (b_src),
		.base    (base_q),
		.res     (mac_res),
		.acc_low (mac_acc_low)
	);

	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= START_STEP;
			zeta_q <= DAMPING_RATIO_RESET;
			base_q <= BASE_FREQUENCY_RESET;
			per_speed_q <= FREQUENCY_PER_SPEED_RESET;
			speed_q <= SPEED_SETTING_RESET;
			x_q <= '0;
			v_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DAMPING_RATIO:       zeta_q <= cfg_data;
					REG_BASE_FREQUENCY:      base_q <= cfg_data;
					REG_FREQUENCY_PER_SPEED: per_speed_q <= cfg_data;
					REG_SPEED_SETTING:       speed_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (go) begin
				pc_q <= (uw.seq == SEQ_WAIT_SLOT) ? uw.target : pc_q + 1'b1;
			end
			if (go && uw.op == OP_FINISH) begin
				result_valid_q <= 1'b1;
				x_q <= snap ? tgt_q : x1_q;
				v_q <= snap ? 32'sd0 : v1_q;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			unique case (uw.op)
				OP_ACCEPT: begin
					tgt_q <= item.target_position;
					us_q <= us_eff;
					err0_q <= err0_in;
				end
				OP_STORE: begin
					unique case (uw.dest)
						D_OMEGA: omega_q <= mac_res[23:0];
						D_K1:    k1_q <= mac_res[40:0];
						D_W2:    w2_q <= mac_res[47:0];
						D_DT:    dt_q <= mac_res[27:0];
						D_T1:    t1_q <= mac_res[50:0];
						D_T2:    t2_q <= mac_res[62:0];
						D_DV:    dv_q <= mac_res[59:0];
						D_DX:    dx_q <= mac_res[28:0];
						default: ;
					endcase
				end
				OP_FIXDT: dt_q <= dt_q + {27'd0, dt_carry};
				OP_VEL:   v1_q <= sat32($signed({{3{vel_sum[60]}}, vel_sum}));
				OP_POS:   x1_q <= sat32($signed({{31{pos_sum[32]}}, pos_sum}));
				OP_FINISH: begin
					result_q.position_out <= snap ? tgt_q : x1_q;
					result_q.velocity_out <= snap ? 32'sd0 : v1_q;
					result_q.settled <= snap;
				end
				default: ;
			endcase
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= LAST_STEP)
		else $error("step counter left the program");

	a_frame_time: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q != START_STEP |-> (us_q != 16'd0 && us_q <= DT_MAX_US))
		else $error("frame time outside the clamped range while running");

	a_settled_still: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.settled) |-> result_q.velocity_out == 32'sd0)
		else $error("settled result with nonzero velocity");

	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		(go && uw.op == OP_FINISH) |=> (result_valid_q &&
		x_q == result_q.position_out && v_q == result_q.velocity_out))
		else $error("state and result beat disagree");

endmodule

// ===== src/dsps_mac.sv =====
`timescale 1ns / 1ps

module dsps_mac (
	input  logic               clk,
	input  dsps_pkg::mac_ctl_t ctl,
	input  logic signed [63:0] a_src,
	input  logic [63:0]        b_src,
	input  logic [15:0]        base,
	output logic signed [63:0] res,
	output logic [47:0]        acc_low
);
	import dsps_pkg::*;

	logic [63:0] ma_q;
	logic [63:0] mb_q;
	logic        sg_q;
	logic [95:0] acc_q;

	logic [63:0] a_mag;
	logic [31:0] a_part;
	logic [31:0] b_part;
	logic [63:0] prod;
	logic [95:0] part;
	logic [6:0]  amount;
	logic [95:0] half;
	logic [95:0] shifted;
	logic [61:0] mag;

	function automatic logic [6:0] sh_amount(sh_t sh);
		logic [6:0] n;
		unique case (sh)
			SH_0:    n = 7'd0;
			SH_16:   n = 7'd16;
			SH_22:   n = 7'd22;
			SH_32:   n = 7'd32;
			SH_48:   n = 7'd48;
			default: n = 7'd0;
		endcase
		return n;
	endfunction

	always_comb begin
		a_mag = a_src[63] ? $unsigned(-a_src) : $unsigned(a_src);
		a_part = ctl.a_hi ? ma_q[63:32] : ma_q[31:0];
		b_part = ctl.b_hi ? mb_q[63:32] : mb_q[31:0];
		prod = a_part * b_part;
		case ({ctl.a_hi, ctl.b_hi}) inside
			2'b00:        part = {32'd0, prod};
			2'b01, 2'b10: part = {prod, 32'd0};
			default:      part = {prod[31:0], 64'd0};
		endcase
		amount = sh_amount(ctl.sh);
		half = (ctl.sh == SH_0) ? '0 : (96'd1 << (amount - 7'd1));
		shifted = acc_q >> amount;
		mag = (shifted > 96'(TERM_CAP)) ? TERM_CAP : shifted[61:0];
		res = sg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
		acc_low = acc_q[47:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ma_q <= a_mag;
			mb_q <= b_src;
			sg_q <= a_src[63];
			unique case (ctl.init)
				INIT_ZERO: acc_q <= '0;
				INIT_HALF: acc_q <= half;
				INIT_BASE: acc_q <= {80'd0, base};
				default:   acc_q <= '0;
			endcase
		end else if (ctl.mul) begin
			acc_q <= acc_q + part;
		end
	end

endmodule

// ===== dv/damped_spring_position_step_tb.sv =====
`timescale 1ns / 1ps

module damped_spring_position_step_tb;
	import dsps_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES = 7;
	localparam int STEPS_PER_PHASE = 105;
	localparam logic [CFG_INDEX_W-1:0] REG_NONE = REG_SPEED_SETTING + 8'd1;
	localparam logic [63:0] FRAME_DEFAULT_US = 64'd16667;
	localparam logic [63:0] FRAME_MAX_US = 64'd33333;
	localparam logic [63:0] US_PER_SECOND = 64'd1000000;
	localparam logic [63:0] TERM_LIMIT = 64'd1 << 61;
	localparam logic signed [63:0] HALF_PIXEL = 64'sd32768;

	typedef struct packed {
		item_t   beat;
		logic    known;
		result_t want;
	} directed_row_t;

	// Rows marked known have a result that follows directly from the rest state or from an
	// error already below half a pixel; the others are checked by the spring predictor.
	localparam directed_row_t DIRECTED_STEPS [20] = '{
		'{'{32'sh0000_0000, 16'd0}, 1'b1, '{32'sh0000_0000, 32'sh0, 1'b1}},
		'{'{32'sh0000_7FFF, 16'd16667}, 1'b1, '{32'sh0000_7FFF, 32'sh0, 1'b1}},
		'{'{32'sh0000_7FFF, 16'hFFFF}, 1'b1, '{32'sh0000_7FFF, 32'sh0, 1'b1}},
		'{'{32'sh0000_0000, 16'd1}, 1'b1, '{32'sh0000_0000, 32'sh0, 1'b1}},
		'{'{32'sh0000_8000, 16'd16667}, 1'b0, '0},
		'{'{32'sh7FFF_FFFF, 16'd0}, 1'b0, '0},
		'{'{32'sh7FFF_FFFF, 16'd33333}, 1'b0, '0},
		'{'{32'sh7FFF_FFFF, 16'd33334}, 1'b0, '0},
		'{'{32'sh8000_0000, 16'hFFFF}, 1'b0, '0},
		'{'{32'sh8000_0000, 16'd1}, 1'b0, '0},
		'{'{32'sh8000_0000, 16'h5555}, 1'b0, '0},
		'{'{32'sh5555_5555, 16'hAAAA}, 1'b0, '0},
		'{'{32'shAAAA_AAAA, 16'h8000}, 1'b0, '0},
		'{'{32'sh0064_0000, 16'd16667}, 1'b0, '0},
		'{'{32'sh0064_0000, 16'd16667}, 1'b0, '0},
		'{'{32'sh0064_0000, 16'd33333}, 1'b0, '0},
		'{'{32'sh0064_0000, 16'd33333}, 1'b0, '0},
		'{'{32'shFF9C_0000, 16'd10000}, 1'b0, '0},
		'{'{32'shFF9C_0000, 16'd0}, 1'b0, '0},
		'{'{32'shFF9C_0000, 16'd0}, 1'b0, '0}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [15:0] zeta_q = 16'd13107;
	logic [15:0] base_freq_q = 16'd2432;
	logic [15:0] per_speed_q = 16'd51;
	logic [7:0] speed_q = 8'd50;
	logic signed [31:0] pos_q = '0;
	logic signed [31:0] vel_q = '0;

	result_t awaited_steps[$];
	int steps_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int stall_hold = 0;
	int quiet_cycles = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	damped_spring_position_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] scaled_mag(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] full;
		full = (({64'd0, a} * {64'd0, b}) + (128'd1 << (sh - 1))) >> sh;
		return (full > {64'd0, TERM_LIMIT}) ? TERM_LIMIT : full[63:0];
	endfunction

	function automatic logic signed [63:0] scaled(logic signed [63:0] a, logic [63:0] b, int sh);
		logic [63:0] mag;
		mag = scaled_mag((a < 0) ? $unsigned(-a) : $unsigned(a), b, sh);
		return (a < 0) ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < -64'sh0000_0000_8000_0000)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic result_t spring_step(item_t beat);
		logic [63:0] us, dt, omega, k1, w2;
		logic signed [63:0] tgt, x, v, err0, err1, acc, dv, dx;
		logic signed [31:0] v1, x1;
		logic snap;
		result_t r;
		tgt = beat.target_position;
		us = beat.frame_time_us;
		if (us == 0)
			us = FRAME_DEFAULT_US;
		if (us > FRAME_MAX_US)
			us = FRAME_MAX_US;
		dt = ((us << 32) + US_PER_SECOND / 2) / US_PER_SECOND;
		omega = base_freq_q + per_speed_q * speed_q;
		k1 = 64'd2 * zeta_q * omega;
		w2 = omega * omega;
		x = pos_q;
		v = vel_q;
		err0 = x - tgt;
		acc = -scaled(v, k1, 22) - scaled(err0, w2, 16);
		dv = scaled(acc, dt, 32);
		v1 = clip32(v + dv);
		dx = scaled(v1, dt, 32);
		x1 = clip32(x + dx);
		err1 = x1 - tgt;
		snap = (err0 <= 0 && err1 >= 0) || (err0 >= 0 && err1 <= 0) ||
			(err1 > -HALF_PIXEL && err1 < HALF_PIXEL);
		if (snap) begin
			x1 = tgt[31:0];
			v1 = '0;
		end
		pos_q = x1;
		vel_q = v1;
		r.position_out = x1;
		r.velocity_out = v1;
		r.settled = snap;
		return r;
	endfunction

	task automatic send_step(item_t beat, logic known, result_t want);
		int gap;
		result_t predicted;
		if (steps_sent % 40 == 0)
			tx_calm = ($urandom_range(0, 3) == 0);
		gap = tx_calm ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			item_valid <= 1'b0;
			if ($urandom_range(0, 1) == 1)
				while (results_seen != steps_sent) @(posedge clk);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		do @(posedge clk); while (item_stall);
		steps_sent++;
		predicted = spring_step(beat);
		awaited_steps.push_back(known ? want : predicted);
	endtask

	task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DAMPING_RATIO: zeta_q = data;
			REG_BASE_FREQUENCY: base_freq_q = data;
			REG_FREQUENCY_PER_SPEED: per_speed_q = data;
			REG_SPEED_SETTING: speed_q = data[7:0];
			default: ;
		endcase
	endtask

	task automatic settle();
		while (results_seen != steps_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_side
		result_t want;
		if (arst_n && result_valid) begin
			if (!result_stall) begin
				if (awaited_steps.size() == 0) begin
					$error("result beat with no step pending");
					mismatches++;
				end else begin
					want = awaited_steps.pop_front();
					if (result.position_out !== want.position_out) begin
						$error("position_out: expected %0d, got %0d",
							want.position_out, result.position_out);
						mismatches++;
					end
					if (result.velocity_out !== want.velocity_out) begin
						$error("velocity_out: expected %0d, got %0d",
							want.velocity_out, result.velocity_out);
						mismatches++;
					end
					if (result.settled !== want.settled) begin
						$error("settled: expected %0d, got %0d", want.settled, result.settled);
						mismatches++;
					end
				end
				if (results_seen % 40 == 0)
					rx_calm = ($urandom_range(0, 3) == 0);
				results_seen <= results_seen + 1;
				// The stall for the next beat is raised now and counted once that beat shows up.
				stall_hold = rx_calm ? 0 : $urandom_range(0, 19);
				result_stall <= (stall_hold != 0);
			end else if (stall_hold > 1) begin
				stall_hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : run
		int phase, n, run_left, pick;
		logic signed [31:0] goal;
		item_t beat;
		run_left = 0;
		goal = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED_STEPS[i])
			send_step(DIRECTED_STEPS[i].beat, DIRECTED_STEPS[i].known, DIRECTED_STEPS[i].want);
		item_valid <= 1'b0;
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: begin
					set_register(REG_DAMPING_RATIO, 16'd13107);
					set_register(REG_BASE_FREQUENCY, 16'd2432);
					set_register(REG_FREQUENCY_PER_SPEED, 16'd51);
					set_register(REG_SPEED_SETTING, 16'd50);
					set_register(REG_NONE, 16'($urandom));
				end
				1: begin
					set_register(REG_DAMPING_RATIO, 16'd11469);
					set_register(REG_BASE_FREQUENCY, 16'd2048);
					set_register(REG_FREQUENCY_PER_SPEED, 16'd51);
					set_register(REG_SPEED_SETTING, 16'd50);
				end
				2: begin
					set_register(REG_DAMPING_RATIO, 16'd0);
					set_register(REG_BASE_FREQUENCY, 16'd0);
					set_register(REG_FREQUENCY_PER_SPEED, 16'd0);
					set_register(REG_SPEED_SETTING, 16'd0);
				end
				3: begin
					set_register(REG_DAMPING_RATIO, 16'hFFFF);
					set_register(REG_BASE_FREQUENCY, 16'hFFFF);
					set_register(REG_FREQUENCY_PER_SPEED, 16'hFFFF);
					set_register(REG_SPEED_SETTING, 16'hFFFF);
				end
				4: begin
					set_register(REG_DAMPING_RATIO, 16'($urandom));
					set_register(REG_BASE_FREQUENCY, 16'($urandom));
					set_register(REG_FREQUENCY_PER_SPEED, 16'($urandom));
					set_register(REG_SPEED_SETTING, 16'($urandom));
					set_register(CFG_INDEX_W'($urandom_range(REG_NONE, 255)), 16'($urandom));
				end
				5: begin
					set_register(REG_DAMPING_RATIO, 16'd0);
					set_register(REG_BASE_FREQUENCY, 16'($urandom_range(0, 4096)));
					set_register(REG_FREQUENCY_PER_SPEED, 16'($urandom_range(0, 64)));
					set_register(REG_SPEED_SETTING, 16'd255);
				end
				default: begin
					set_register(REG_DAMPING_RATIO, 16'($urandom_range(8192, 32768)));
					set_register(REG_BASE_FREQUENCY, 16'($urandom_range(256, 8192)));
					set_register(REG_FREQUENCY_PER_SPEED, 16'd0);
					set_register(REG_SPEED_SETTING, 16'($urandom_range(0, 255)));
				end
			endcase
			cfg_valid <= 1'b0;
			for (n = 0; n < STEPS_PER_PHASE; n++) begin
				if (run_left == 0) begin
					pick = $urandom_range(0, 9);
					case (pick)
						0: goal = $urandom;
						1: goal = pos_q + (int'($urandom_range(0, 65534)) - 32767);
						2: goal = 32'sh7FFF_FFFF;
						3: goal = 32'sh8000_0000;
						default: goal = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
					endcase
					run_left = $urandom_range(1, 30);
				end
				run_left--;
				beat.target_position = ($urandom_range(0, 11) == 0) ? $urandom : goal;
				pick = $urandom_range(0, 9);
				case (pick)
					0: beat.frame_time_us = 16'd0;
					1: beat.frame_time_us = 16'($urandom_range(33334, 65535));
					2: beat.frame_time_us = 16'($urandom);
					default: beat.frame_time_us = 16'($urandom_range(1, 33333));
				endcase
				send_step(beat, 1'b0, '0);
			end
			item_valid <= 1'b0;
		end
		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
